// ===== rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes for the binary heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int KEY_W       = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int DEPTH_DEF   = 64;

  // Register indexes on the config port (word index)
  localparam logic REG_DESC_ORDER = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_WAIT,
    S_RESP
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [KEY_W-1:0]       top_key;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

endpackage

// ===== rtl/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hpq_cell.sv =====
// ----------------------------------------------------------------------------
// hpq_cell
// One heap level. Holds the level's nodes as sibling pairs (left / right RAM)
// and moves the sift token one level per cycle, up or down the chain.
// Node numbers are 1-based: children of n are 2n and 2n+1.
// ----------------------------------------------------------------------------
module hpq_cell import hpq_pkg::*; #(
  parameter int LEVEL = 0,
  parameter int NW    = 7,
  parameter int KW    = KEY_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          desc,
  input  logic [NW-1:0] count,
  // sift-down token from the level above: parent node n, carried key
  input  logic          dn_in_vld,
  input  logic [NW-1:0] dn_in_n,
  input  logic [KW-1:0] dn_in_key,
  output logic          dn_out_vld,
  output logic [NW-1:0] dn_out_n,
  output logic [KW-1:0] dn_out_key,
  // sift-up token from the level below: child node c, carried key
  input  logic          up_in_vld,
  input  logic [NW-1:0] up_in_n,
  input  logic [KW-1:0] up_in_key,
  output logic          up_out_vld,
  output logic [NW-1:0] up_out_n,
  output logic [KW-1:0] up_out_key,
  // writes into this level from a neighbor or the controller
  input  logic          wr_in_vld,
  input  logic [NW-1:0] wr_in_n,
  input  logic [KW-1:0] wr_in_data,
  // writes to the parent and child levels
  output logic          pw_vld,
  output logic [NW-1:0] pw_n,
  output logic [KW-1:0] pw_data,
  output logic          cw_vld,
  output logic [NW-1:0] cw_n,
  output logic [KW-1:0] cw_data,
  // fetch of one node, data in the next cycle
  input  logic [NW-1:0] fe_n,
  output logic [KW-1:0] fe_data,
  output logic          done
);

  localparam int ROWS   = (LEVEL < 2) ? 1 : (1 << (LEVEL - 1));
  localparam int ROW_AW = (LEVEL < 3) ? 1 : (LEVEL - 1);
  localparam logic [NW-1:0] ONE_N = NW'(1);

  function automatic logic above(input logic [KW-1:0] a, input logic [KW-1:0] b,
                                 input logic d);
    above = d ? (a > b) : (a < b);
  endfunction

  logic              ph_dn;
  logic              ph_up;
  logic [NW-1:0]     n_r;
  logic [KW-1:0]     key_r;
  logic              half_r;

  logic [NW-1:0]     rd_row;
  logic [ROW_AW-1:0] rd_addr;
  logic [KW-1:0]     rd_l;
  logic [KW-1:0]     rd_r;

  logic              own_vld;
  logic [NW-1:0]     own_n;
  logic              w_vld;
  logic [NW-1:0]     w_n;
  logic [KW-1:0]     w_data;
  logic [NW-1:0]     w_row;
  logic [ROW_AW-1:0] w_addr;

  // sift-down compare
  logic              r_ok;
  logic              sel_l;
  logic              sel_r;
  logic [KW-1:0]     best0;
  logic              moved;
  logic [KW-1:0]     mv_val;
  logic [NW-1:0]     c_dn;
  logic              deeper;
  // sift-up compare
  logic [NW-1:0]     p_up;
  logic [KW-1:0]     up_val;
  logic              go;
  logic              at_root;

  // read row: children pair of a parent, the pair holding a parent, or a fetch
  always_comb begin
    if (dn_in_vld) begin
      rd_row = dn_in_n;
    end else if (up_in_vld) begin
      rd_row = up_in_n >> 2;
    end else begin
      rd_row = fe_n >> 1;
    end
    rd_addr = (ROWS > 1) ? rd_row[ROW_AW-1:0] : '0;
  end

  always_comb begin
    r_ok   = {n_r, 1'b1} <= {1'b0, count};
    sel_l  = above(rd_l, key_r, desc);
    best0  = sel_l ? rd_l : key_r;
    sel_r  = r_ok && above(rd_r, best0, desc);
    moved  = sel_l | sel_r;
    mv_val = sel_r ? rd_r : rd_l;
    c_dn   = {n_r[NW-2:0], sel_r};
    deeper = {c_dn, 1'b0} <= {1'b0, count};

    p_up    = n_r >> 1;
    up_val  = n_r[1] ? rd_r : rd_l;
    go      = above(key_r, up_val, desc);
    at_root = (p_up == ONE_N);
  end

  always_comb begin
    pw_vld     = ph_dn;
    pw_n       = n_r;
    pw_data    = moved ? mv_val : key_r;
    dn_out_vld = ph_dn & moved & deeper;
    dn_out_n   = c_dn;
    dn_out_key = key_r;

    cw_vld     = ph_up;
    cw_n       = n_r;
    cw_data    = go ? up_val : key_r;
    up_out_vld = ph_up & go & ~at_root;
    up_out_n   = p_up;
    up_out_key = key_r;

    done = (ph_dn & ~(moved & deeper)) | (ph_up & ~(go & ~at_root));

    // carried key lands in this level at the end of a sift
    own_vld = (ph_dn & moved & ~deeper) | (ph_up & go & at_root);
    own_n   = ph_dn ? c_dn : p_up;

    w_vld  = own_vld | wr_in_vld;
    w_n    = own_vld ? own_n : wr_in_n;
    w_data = own_vld ? key_r : wr_in_data;
    w_row  = w_n >> 1;
    w_addr = (ROWS > 1) ? w_row[ROW_AW-1:0] : '0;

    fe_data = half_r ? rd_r : rd_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_dn <= 1'b0;
      ph_up <= 1'b0;
    end else begin
      ph_dn <= dn_in_vld;
      ph_up <= up_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_in_vld) begin
      n_r   <= dn_in_n;
      key_r <= dn_in_key;
    end else if (up_in_vld) begin
      n_r   <= up_in_n;
      key_r <= up_in_key;
    end
    half_r <= fe_n[0];
  end

  hpq_ram #(
    .WIDTH (KW),
    .DEPTH (ROWS)
  ) u_ram_l (
    .clk   (clk),
    .we    (w_vld & ~w_n[0]),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (rd_addr),
    .rdata (rd_l)
  );

  hpq_ram #(
    .WIDTH (KW),
    .DEPTH (ROWS)
  ) u_ram_r (
    .clk   (clk),
    .we    (w_vld & w_n[0]),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (rd_addr),
    .rdata (rd_r)
  );

endmodule

// ===== rtl/binary_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top: min/max binary heap, one cell per heap level
// Items are handled one at a time; the sift token walks one heap level per cycle,
//   and start is taken in the idle cycle after the result beat.
// Reset (rst, sync, active high): heap empty, ascending order; RAMs not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top import hpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  // result channel: one beat per item, no backpressure
  output logic        done,
  output result_t     result,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Levels 0..LEVELS-1; node numbers are 1-based and fit in LEVELS bits,
  // which also holds the entry count (0..DEPTH).
  localparam int LEVELS = $clog2(DEPTH + 1);
  localparam int NW     = LEVELS;
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
  localparam logic [NW-1:0] ONE_N   = NW'(1);
  localparam logic [NW-1:0] TWO_N   = NW'(2);

  ctl_state_t state;
  ctl_state_t state_next;

  logic                 descending_order;
  logic [1:0]           op;
  logic [KEY_W-1:0]     key_in;
  logic [NW-1:0]        count;
  logic [1:0]           status_r;
  logic [KEY_W-1:0]     top_r;

  logic [NW-1:0]        n_ins;
  logic                 full;
  logic [KEY_W-1:0]     last_val;
  logic [NW+COUNT_OUT_W-1:0] cnt_ext;

  // controller injections into the chain
  logic                 inj_up_vld;
  logic                 inj_dn_vld;
  logic [KEY_W-1:0]     inj_dn_key;
  logic                 ctl_wr_vld;
  logic [KEY_W-1:0]     ctl_wr_data;

  // per-cell outputs
  logic                 dno_vld [LEVELS];
  logic [NW-1:0]        dno_n   [LEVELS];
  logic [KEY_W-1:0]     dno_key [LEVELS];
  logic                 upo_vld [LEVELS];
  logic [NW-1:0]        upo_n   [LEVELS];
  logic [KEY_W-1:0]     upo_key [LEVELS];
  logic                 pw_vld  [LEVELS];
  logic [NW-1:0]        pw_n    [LEVELS];
  logic [KEY_W-1:0]     pw_data [LEVELS];
  logic                 cw_vld  [LEVELS];
  logic [NW-1:0]        cw_n    [LEVELS];
  logic [KEY_W-1:0]     cw_data [LEVELS];
  logic [KEY_W-1:0]     fe_data [LEVELS];
  logic [LEVELS-1:0]    cell_done;
  logic [LEVELS-1:0]    sel_last;

  // --------------------------------------------------------------------------
  // Config port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending_order <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DESC_ORDER: descending_order <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DESC_ORDER: prdata = {31'd0, descending_order};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  assign n_ins = count + ONE_N;
  assign full  = (count == DEPTH_N);

  // data of the last node, from the cell holding its level
  always_comb begin
    last_val = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (sel_last[k]) begin
        last_val = fe_data[k];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op == OP_INSERT) begin
          state_next = (full || count == '0) ? S_RESP : S_WAIT;
        end else if (op == OP_EXTRACT || op == OP_PEEK) begin
          state_next = (count == '0) ? S_RESP : S_FETCH;
        end else begin
          state_next = S_RESP;
        end
      end
      S_FETCH: begin
        // extract with three or more keys needs a sift-down
        state_next = (op == OP_EXTRACT && count > TWO_N) ? S_WAIT : S_RESP;
      end
      S_WAIT: begin
        if (|cell_done) state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != S_IDLE);
    done        = (state == S_RESP);
    inj_up_vld  = 1'b0;
    inj_dn_vld  = 1'b0;
    inj_dn_key  = last_val;
    ctl_wr_vld  = 1'b0;
    ctl_wr_data = key_in;
    unique case (state)
      S_EXEC: begin
        if (op == OP_INSERT && !full) begin
          // first key goes straight to the root, else sift up from the new leaf
          ctl_wr_vld = (count == '0);
          inj_up_vld = (count != '0);
        end
      end
      S_FETCH: begin
        if (op == OP_EXTRACT) begin
          ctl_wr_vld  = (count == TWO_N);
          ctl_wr_data = last_val;
          inj_dn_vld  = (count > TWO_N);
        end
      end
      default: ;
    endcase
    cnt_ext = {{COUNT_OUT_W{1'b0}}, count};
    result.status      = status_r;
    result.top_key     = top_r;
    result.entry_count = cnt_ext[COUNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && op == OP_INSERT && !full) begin
        count <= n_ins;
      end else if (state == S_FETCH && op == OP_EXTRACT) begin
        count <= count - ONE_N;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op     <= item.opcode;
      key_in <= item.key;
    end
    if (state == S_EXEC) begin
      top_r    <= '0;
      status_r <= ST_OK;
      if (op == OP_INSERT && full) begin
        status_r <= ST_FULL;
      end else if ((op == OP_EXTRACT || op == OP_PEEK) && count == '0) begin
        status_r <= ST_EMPTY;
      end
    end
    if (state == S_FETCH) begin
      top_r <= fe_data[0];
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell k holds heap level k
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    logic             din_vld;
    logic [NW-1:0]    din_n;
    logic [KEY_W-1:0] din_key;
    logic             uin_vld;
    logic [NW-1:0]    uin_n;
    logic [KEY_W-1:0] uin_key;
    logic             inj_here;
    logic             win_vld;
    logic [NW-1:0]    win_n;
    logic [KEY_W-1:0] win_data;
    logic             from_below;
    logic             from_above;
    logic [NW-1:0]    fe_n;

    assign sel_last[k] = ((count >> k) == ONE_N);
    assign fe_n        = sel_last[k] ? count : ONE_N;
    // new leaf sits at level k+1: this cell reads its parent
    assign inj_here    = inj_up_vld && ((n_ins >> (k + 1)) == ONE_N);

    if (k == 0) begin : g_dn_first
      assign din_vld = 1'b0;
      assign din_n   = '0;
      assign din_key = '0;
    end else begin : g_dn_link
      // extract starts its sift-down at the root's children
      assign din_vld = dno_vld[k-1] | (inj_dn_vld && k == 1);
      assign din_n   = (inj_dn_vld && k == 1) ? ONE_N : dno_n[k-1];
      assign din_key = (inj_dn_vld && k == 1) ? inj_dn_key : dno_key[k-1];
    end

    if (k == LEVELS - 1) begin : g_up_last
      assign uin_vld = inj_here;
      assign uin_n   = n_ins;
      assign uin_key = key_in;
    end else begin : g_up_link
      assign uin_vld = upo_vld[k+1] | inj_here;
      assign uin_n   = inj_here ? n_ins : upo_n[k+1];
      assign uin_key = inj_here ? key_in : upo_key[k+1];
    end

    if (k < LEVELS - 1) begin : g_wb
      assign from_below = pw_vld[k+1];
    end else begin : g_wb_none
      assign from_below = 1'b0;
    end
    if (k > 0) begin : g_wa
      assign from_above = cw_vld[k-1];
    end else begin : g_wa_none
      assign from_above = 1'b0;
    end

    always_comb begin
      win_vld  = from_below | from_above | (ctl_wr_vld && k == 0);
      win_n    = ONE_N;
      win_data = ctl_wr_data;
      if (from_below) begin
        win_n    = pw_n[(k < LEVELS - 1) ? k + 1 : k];
        win_data = pw_data[(k < LEVELS - 1) ? k + 1 : k];
      end else if (from_above) begin
        win_n    = cw_n[(k > 0) ? k - 1 : k];
        win_data = cw_data[(k > 0) ? k - 1 : k];
      end
    end

    hpq_cell #(
      .LEVEL (k),
      .NW    (NW),
      .KW    (KEY_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .desc       (descending_order),
      .count      (count),
      .dn_in_vld  (din_vld),
      .dn_in_n    (din_n),
      .dn_in_key  (din_key),
      .dn_out_vld (dno_vld[k]),
      .dn_out_n   (dno_n[k]),
      .dn_out_key (dno_key[k]),
      .up_in_vld  (uin_vld),
      .up_in_n    (uin_n),
      .up_in_key  (uin_key),
      .up_out_vld (upo_vld[k]),
      .up_out_n   (upo_n[k]),
      .up_out_key (upo_key[k]),
      .wr_in_vld  (win_vld),
      .wr_in_n    (win_n),
      .wr_in_data (win_data),
      .pw_vld     (pw_vld[k]),
      .pw_n       (pw_n[k]),
      .pw_data    (pw_data[k]),
      .cw_vld     (cw_vld[k]),
      .cw_n       (cw_n[k]),
      .cw_data    (cw_data[k]),
      .fe_n       (fe_n),
      .fe_data    (fe_data[k]),
      .done       (cell_done[k])
    );
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a sift never runs off either end of the chain
  a_chain_ends: assert property (@(posedge clk) disable iff (rst)
    !(upo_vld[0] || pw_vld[0] || dno_vld[LEVELS-1] || cw_vld[LEVELS-1]))
    else $error("sift token left the cell chain");

  // cells finish only while the controller waits on a sift
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    |cell_done |-> state == S_WAIT)
    else $error("cell finished outside a sift");

  // entry count stays within the heap size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_N)
    else $error("entry count above depth");

  // each accepted item gives one result beat, then the block is free
  a_beat_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("result beat not followed by idle");
`endif

endmodule

// ===== dv/tb_binary_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_top
// Self-checking bench for the heap priority queue: a behavioral heap tracks
// every accepted command, and each result beat is checked field by field in
// order. A short directed part is followed by random fill, drain and mixed
// phases under both orderings, with random start gaps.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue_top;
  import hpq_pkg::*;

  localparam int            HEAP_DEPTH   = DEPTH_DEF;
  localparam int            RANDOM_ITEMS = 1050;
  localparam int            STALL_LIMIT  = 2000;  // cycles with no beat either way
  localparam int            DRAIN_CYCLES = 24;    // well past the worst-case sift
  localparam int            MAX_REPORTS  = 10;
  localparam logic [1:0]    OP_UNUSED    = 2'd3;  // no-op code, state untouched
  localparam logic [31:0]   KEY_MAX      = 32'hFFFF_FFFF;

  // traffic mix of one random phase
  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  binary_heap_priority_queue_top #(
    .DEPTH(HEAP_DEPTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Behavioral heap: array, fill level and ordering as the bench believes them
  // --------------------------------------------------------------------------
  logic [31:0] heap_keys [HEAP_DEPTH];
  int          heap_fill;
  logic        largest_first;

  // results owed by the block, oldest first
  result_t     heap_replies_q [$];
  int          mismatches;
  int          stall_cycles;

  // true when key a sits nearer the root than key b
  function automatic bit outranks(logic [31:0] a, logic [31:0] b);
    return largest_first ? (a > b) : (a < b);
  endfunction

  function automatic void swap_keys(int i, int k);
    logic [31:0] t;
    t            = heap_keys[i];
    heap_keys[i] = heap_keys[k];
    heap_keys[k] = t;
  endfunction

  // Apply one command to the heap and return the result it must produce.
  function automatic result_t heap_apply(logic [1:0] op, logic [31:0] key);
    result_t r;
    int      pos;
    int      up;
    int      lc;
    int      rc;
    int      best;
    r.status      = ST_OK;
    r.top_key     = '0;
    case (op)
      OP_INSERT: begin
        if (heap_fill >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          heap_keys[heap_fill] = key;
          heap_fill++;
          pos = heap_fill - 1;
          // sift up, stopping at an equal key
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!outranks(heap_keys[pos], heap_keys[up])) break;
            swap_keys(pos, up);
            pos = up;
          end
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (heap_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_key = heap_keys[0];
          if (op == OP_EXTRACT) begin
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            // sift down toward the better child
            while (pos < heap_fill) begin
              lc   = 2 * pos + 1;
              rc   = lc + 1;
              best = pos;
              if (lc < heap_fill && outranks(heap_keys[lc], heap_keys[best])) best = lc;
              if (rc < heap_fill && outranks(heap_keys[rc], heap_keys[best])) best = rc;
              if (best == pos) break;
              swap_keys(pos, best);
              pos = best;
            end
          end
        end
      end
      default: ;  // unused code: nothing moves
    endcase
    r.entry_count = heap_fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    if (mismatches < MAX_REPORTS)
      $display("%0t: mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, act_v);
    mismatches++;
  endtask

  // Drive one command beat; returns right after the edge that took it.
  // start is left high so back-to-back beats need no extra edge.
  task automatic send_command(input logic [1:0] op, input logic [31:0] key);
    @(negedge clk);
    start       <= 1'b1;
    item.opcode <= op;
    item.key    <= key;
    do @(posedge clk); while (busy);
    heap_replies_q.push_back(heap_apply(op, key));
  endtask

  // Random idle time after a beat: mostly none or short, now and then long.
  task automatic start_gap(input bit no_idle);
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Keys: full range, narrow bands at either end full of duplicates, or the corners.
  function automatic logic [31:0] pick_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom;
    if (pick < 72) return $urandom_range(0, 15);
    if (pick < 80) return KEY_MAX - $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return KEY_MAX;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Ordering register write plus read-back, only once the block is drained.
  task automatic write_order_reg(input logic desc);
    @(negedge clk);
    start <= 1'b0;
    while (heap_replies_q.size() != 0 || busy) @(posedge clk);
    // write: setup then access
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DESC_ORDER, 2'b00};
    pwdata  <= {31'b0, desc};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    largest_first = desc;
    // read back the same register
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, desc})
      report_mismatch("order readback", 64'({31'b0, desc}), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every done beat against the oldest owed result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (heap_replies_q.size() == 0) begin
        report_mismatch("result beat with nothing owed", '0, 64'(result));
      end else begin
        want = heap_replies_q.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(result.status));
        if (result.top_key !== want.top_key)
          report_mismatch("top_key", 64'(want.top_key), 64'(result.top_key));
        if (result.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(want.entry_count),
                          64'(result.entry_count));
      end
    end
  end

  // Watchdog: any command or result beat counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight out of reset: empty extract/peek and the no-op code.
  task automatic test_empty_queue();
    send_command(OP_PEEK, KEY_MAX);
    send_command(OP_EXTRACT, 32'h0);
    send_command(OP_UNUSED, KEY_MAX);
    start_gap(1'b0);
  endtask

  // Smallest-first: corner keys, a duplicate, drain past empty.
  task automatic test_key_extremes();
    write_order_reg(1'b0);
    send_command(OP_INSERT, KEY_MAX);
    send_command(OP_INSERT, 32'h0);
    send_command(OP_INSERT, 32'h8000_0000);
    send_command(OP_INSERT, 32'h0);
    send_command(OP_PEEK, 32'h1234_5678);
    repeat (4) send_command(OP_EXTRACT, KEY_MAX);
    send_command(OP_EXTRACT, 32'h0);
    start_gap(1'b0);
  endtask

  // Largest-first, with a no-op in the middle of a populated heap.
  task automatic test_largest_first();
    write_order_reg(1'b1);
    send_command(OP_INSERT, 32'h0);
    send_command(OP_INSERT, KEY_MAX);
    send_command(OP_INSERT, 32'h7FFF_FFFF);
    send_command(OP_PEEK, 32'h0);
    send_command(OP_UNUSED, KEY_MAX);
    repeat (3) send_command(OP_EXTRACT, 32'h0);
    start_gap(1'b0);
  endtask

  // Phases of fill (runs into full), drain (runs into empty) and mixed
  // traffic; the ordering flips between phases, sometimes with keys held.
  task automatic test_random_traffic();
    int         counted;
    int         n;
    int         pick;
    bit         no_idle;
    phase_t     kind;
    logic [1:0] op;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind    = phase_t'($urandom_range(0, 2));
      n       = $urandom_range(30, 110);
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_order_reg(!largest_first);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        case (kind)
          PH_FILL:  op = (pick < 88) ? OP_INSERT : (pick < 95) ? OP_PEEK :
                         (pick < 98) ? OP_EXTRACT : OP_UNUSED;
          PH_DRAIN: op = (pick < 80) ? OP_EXTRACT : (pick < 88) ? OP_PEEK :
                         (pick < 97) ? OP_INSERT : OP_UNUSED;
          default:  op = (pick < 45) ? OP_INSERT : (pick < 85) ? OP_EXTRACT :
                         (pick < 97) ? OP_PEEK : OP_UNUSED;
        endcase
        send_command(op, pick_key());
        if (op != OP_UNUSED) counted++;
        start_gap(no_idle);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    heap_fill     = 0;
    largest_first = 1'b0;
    mismatches    = 0;
    stall_cycles  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_key_extremes();
    test_largest_first();
    test_random_traffic();

    // let the last beats come home, then watch for strays
    @(negedge clk);
    start <= 1'b0;
    while (heap_replies_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
